@@ rtl/core/cpfv_pkg.sv @@
// cpfv_pkg: shared types, constants and helper functions for the
// individual/company number check digit validator. No dependencies.
`default_nettype none

package cpfv_pkg;

  // number of digits an individual or a company number must have
  localparam logic [3:0] CPF_DIGITS  = 4'd11;
  localparam logic [3:0] CNPJ_DIGITS = 4'd14;

  // ascii range of decimal digits
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // x / 11 approximated as (x * 372) >> 12, never above the true quotient
  localparam int unsigned MOD_RECIP = 372;
  localparam int unsigned RECIP_SHIFT = 12;
  localparam logic [4:0] MOD_BASE = 5'd11;

  // input item and result item
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic       valid_res;
    logic [1:0] verdict_code;
  } out_t;

  typedef enum logic [1:0] {
    VERDICT_OK       = 2'd0,
    VERDICT_COUNT    = 2'd1,
    VERDICT_SAME     = 2'd2,
    VERDICT_MISMATCH = 2'd3
  } verdict_t;

  // queue entry between front and back
  typedef enum logic {
    KIND_DIGIT = 1'b0,
    KIND_END   = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] digit;
  } q_entry_t;

  // front to queue
  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } push_t;

  // queue to front/back
  typedef struct packed {
    logic     full;
    logic     empty;
    q_entry_t head;
  } q_status_t;

  // weight of the first check digit sum at a digit position
  function automatic logic [3:0] weight_first(input logic mode, input logic [3:0] pos);
    logic [3:0] w;
    w = 4'd0;
    if (mode) begin
      if (pos < 4'd9) w = 4'd10 - pos;
    end else begin
      unique case (pos)
        4'd0:    w = 4'd5;
        4'd1:    w = 4'd4;
        4'd2:    w = 4'd3;
        4'd3:    w = 4'd2;
        4'd4:    w = 4'd9;
        4'd5:    w = 4'd8;
        4'd6:    w = 4'd7;
        4'd7:    w = 4'd6;
        4'd8:    w = 4'd5;
        4'd9:    w = 4'd4;
        4'd10:   w = 4'd3;
        4'd11:   w = 4'd2;
        default: w = 4'd0;
      endcase
    end
    return w;
  endfunction

  // weight of the second check digit sum at a digit position
  function automatic logic [3:0] weight_second(input logic mode, input logic [3:0] pos);
    logic [3:0] w;
    w = 4'd0;
    if (mode) begin
      if (pos < 4'd10) w = 4'd11 - pos;
    end else begin
      unique case (pos)
        4'd0:    w = 4'd6;
        4'd1:    w = 4'd5;
        4'd2:    w = 4'd4;
        4'd3:    w = 4'd3;
        4'd4:    w = 4'd2;
        4'd5:    w = 4'd9;
        4'd6:    w = 4'd8;
        4'd7:    w = 4'd7;
        4'd8:    w = 4'd6;
        4'd9:    w = 4'd5;
        4'd10:   w = 4'd4;
        4'd11:   w = 4'd3;
        4'd12:   w = 4'd2;
        default: w = 4'd0;
      endcase
    end
    return w;
  endfunction

  // check digit of a sum: r = sum mod 11, digit 0 if r < 2 else 11 - r
  function automatic logic [3:0] check_digit(input logic [9:0] sum);
    logic [18:0] prod;
    logic [6:0]  quot;
    logic [10:0] qx11;
    logic [4:0]  rem;
    logic [3:0]  res;
    prod = 19'(sum) * 19'(MOD_RECIP);
    quot = prod[18:RECIP_SHIFT];
    qx11 = 11'(quot) * 11'(MOD_BASE);
    rem  = 5'(11'(sum) - qx11);
    if (rem >= MOD_BASE) rem = rem - MOD_BASE;
    if (rem < 5'd2) res = 4'd0;
    else res = 4'(MOD_BASE - rem);
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/cpf_cnpj_check_digit_validator_top.sv @@
// Check digit validator for 11-digit individual and 14-digit company
// numbers: top level. Depends on cpfv_pkg, cpfv_front, cpfv_queue, cpfv_back.
//
// Usage:
//   item channel (item_valid / item_stall / item_data): one text byte per
//   transfer; bytes outside '0'..'9' are dropped, a transfer with
//   end_of_text set closes the string and yields one verdict.
//   result channel (res_valid / res_stall / res_data): one verdict per
//   string, valid_res plus verdict_code (ok, count, all equal, mismatch).
//   cfg channel (cfg_valid / cfg_ready / cfg_data): individual_mode, always
//   ready; write it between strings.
// Throughput: one byte per cycle while item_stall is low; the back end
// forms each weighted product and sum combinationally.
// Verdict path: the end marker is stored in the queue; once it is at the head
// and the output register is free, it is judged and the verdict registered.
// Reset: mode returns to individual numbers, sums and counts clear, the
// queue empties and no result is pending.
// Stall: while res_stall holds a verdict, digits keep draining but the next
// end marker waits in the queue; once the queue fills, item_stall rises.
`default_nettype none

module cpf_cnpj_check_digit_validator_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_stall,
  input  wire cpfv_pkg::in_t  item_data,
  output logic                res_valid,
  input  wire logic           res_stall,
  output cpfv_pkg::out_t      res_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic           cfg_data
);

  cpfv_pkg::push_t     push;
  cpfv_pkg::q_status_t q_status;
  logic                pop;

  assign cfg_ready = 1'b1;

  // accept and classify
  cpfv_front u_front (
    .item_valid (item_valid),
    .item_data  (item_data),
    .q_status   (q_status),
    .item_stall (item_stall),
    .push       (push)
  );

  // decoupling queue
  cpfv_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pop      (pop),
    .q_status (q_status)
  );

  // accumulate and judge
  cpfv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .q_status  (q_status),
    .pop       (pop),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  // no push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.push |-> !q_status.full)
    else $error("push into full queue");

  // no pop from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

  // a new result only follows an end entry taken by the back end
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(pop && (q_status.head.kind == cpfv_pkg::KIND_END)))
    else $error("result without end entry");

endmodule

`default_nettype wire

@@ rtl/core/cpfv_front.sv @@
// cpfv_front: accepts text bytes, drops non-digits, and pushes digit and
// end entries into the queue. Depends on cpfv_pkg.
`default_nettype none

module cpfv_front (
  input  wire logic             item_valid,
  input  wire cpfv_pkg::in_t    item_data,
  input  wire cpfv_pkg::q_status_t q_status,
  output logic                  item_stall,
  output cpfv_pkg::push_t       push
);

  logic accept;
  logic is_digit;

  // hold off the sender only while the queue is full
  assign item_stall = q_status.full;
  assign accept     = item_valid && !q_status.full;

  // classify the byte
  assign is_digit = (item_data.char_code >= cpfv_pkg::CHAR_ZERO) &&
                    (item_data.char_code <= cpfv_pkg::CHAR_NINE);

  always_comb begin
    push.push        = accept && (item_data.end_of_text || is_digit);
    push.entry.kind  = item_data.end_of_text ? cpfv_pkg::KIND_END : cpfv_pkg::KIND_DIGIT;
    // low nibble of an ascii digit is its value
    push.entry.digit = item_data.char_code[3:0];
  end

endmodule

`default_nettype wire

@@ rtl/core/cpfv_queue.sv @@
// cpfv_queue: short fifo of classified entries between front and back.
// Depends on cpfv_pkg.
`default_nettype none

module cpfv_queue #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cpfv_pkg::push_t   push,
  input  wire logic              pop,
  output cpfv_pkg::q_status_t    q_status
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cpfv_pkg::q_entry_t entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign do_push = push.push && (count != CNT_W'(QUEUE_DEPTH));
  assign do_pop  = pop && (count != '0);

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        if (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) wr_ptr <= '0;
        else wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        if (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) rd_ptr <= '0;
        else rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_comb begin
    q_status.full  = (count == CNT_W'(QUEUE_DEPTH));
    q_status.empty = (count == '0);
    q_status.head  = entries[rd_ptr];
  end

endmodule

`default_nettype wire

@@ rtl/core/cpfv_back.sv @@
// cpfv_back: weighted digit accumulation, verdict on the end entry and
// the result output register; holds the mode register. Depends on cpfv_pkg.
`default_nettype none

module cpfv_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic                cfg_data,
  input  wire cpfv_pkg::q_status_t q_status,
  output logic                     pop,
  input  wire logic                res_stall,
  output logic                     res_valid,
  output cpfv_pkg::out_t           res_data
);

  logic       individual_mode;
  logic [3:0] digit_count, digit_count_next;
  logic [3:0] first_digit, first_digit_next;
  logic       all_same, all_same_next;
  logic [9:0] first_sum, first_sum_next;
  logic [9:0] second_sum, second_sum_next;
  logic [3:0] previous_digit, previous_digit_next;
  logic [3:0] latest_digit, latest_digit_next;

  logic       out_free;
  logic       take_digit;
  logic       take_end;
  logic [3:0] w1, w2;
  logic [7:0] prod1, prod2;
  logic [3:0] need;
  logic [3:0] check1, check2;
  cpfv_pkg::verdict_t verdict;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      individual_mode <= 1'b1;
    end else if (cfg_we) begin
      individual_mode <= cfg_data;
    end
  end

  // digits always drain; an end entry waits for a free output register
  assign out_free   = !res_valid || !res_stall;
  assign take_digit = !q_status.empty && (q_status.head.kind == cpfv_pkg::KIND_DIGIT);
  assign take_end   = !q_status.empty && (q_status.head.kind == cpfv_pkg::KIND_END) && out_free;
  assign pop        = take_digit || take_end;

  // weighted products for the current position
  always_comb begin
    w1    = cpfv_pkg::weight_first(individual_mode, digit_count);
    w2    = cpfv_pkg::weight_second(individual_mode, digit_count);
    prod1 = 8'(q_status.head.digit) * 8'(w1);
    prod2 = 8'(q_status.head.digit) * 8'(w2);
  end

  // verdict from the accumulated state
  always_comb begin
    need   = individual_mode ? cpfv_pkg::CPF_DIGITS : cpfv_pkg::CNPJ_DIGITS;
    check1 = cpfv_pkg::check_digit(first_sum);
    check2 = cpfv_pkg::check_digit(second_sum);
    if (digit_count != need) verdict = cpfv_pkg::VERDICT_COUNT;
    else if (all_same) verdict = cpfv_pkg::VERDICT_SAME;
    else if ((check1 != previous_digit) || (check2 != latest_digit))
      verdict = cpfv_pkg::VERDICT_MISMATCH;
    else verdict = cpfv_pkg::VERDICT_OK;
  end

  // next accumulation state
  always_comb begin
    digit_count_next    = digit_count;
    first_digit_next    = first_digit;
    all_same_next       = all_same;
    first_sum_next      = first_sum;
    second_sum_next     = second_sum;
    previous_digit_next = previous_digit;
    latest_digit_next   = latest_digit;
    if (take_digit) begin
      first_sum_next      = first_sum + 10'(prod1);
      second_sum_next     = second_sum + 10'(prod2);
      if (digit_count == 4'd0) first_digit_next = q_status.head.digit;
      else if (q_status.head.digit != first_digit) all_same_next = 1'b0;
      previous_digit_next = latest_digit;
      latest_digit_next   = q_status.head.digit;
      if (digit_count != 4'd15) digit_count_next = digit_count + 4'd1;
    end else if (take_end) begin
      digit_count_next    = 4'd0;
      first_digit_next    = 4'd0;
      all_same_next       = 1'b1;
      first_sum_next      = 10'd0;
      second_sum_next     = 10'd0;
      previous_digit_next = 4'd0;
      latest_digit_next   = 4'd0;
    end
  end

  // accumulation registers
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count    <= 4'd0;
      first_digit    <= 4'd0;
      all_same       <= 1'b1;
      first_sum      <= 10'd0;
      second_sum     <= 10'd0;
      previous_digit <= 4'd0;
      latest_digit   <= 4'd0;
    end else begin
      digit_count    <= digit_count_next;
      first_digit    <= first_digit_next;
      all_same       <= all_same_next;
      first_sum      <= first_sum_next;
      second_sum     <= second_sum_next;
      previous_digit <= previous_digit_next;
      latest_digit   <= latest_digit_next;
    end
  end

  // result output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take_end) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_end) begin
      res_data.valid_res    <= (verdict == cpfv_pkg::VERDICT_OK);
      res_data.verdict_code <= verdict;
    end
  end

endmodule

`default_nettype wire
